### src/grid_maze_depth_first_solver_core_macros.svh
// assertion macros for the grid maze depth-first solver
`ifndef GRID_MAZE_DEPTH_FIRST_SOLVER_CORE_MACROS_SVH
`define GRID_MAZE_DEPTH_FIRST_SOLVER_CORE_MACROS_SVH

// same-cycle implication
`define GMD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define GMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### src/gmd_pkg.sv
// types and constants shared by the grid maze solver modules
package gmd_pkg;

    localparam int CELL_W   = 4;
    localparam int GRID_MIN = 2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SOLVE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_PATH = 2'd1;
    localparam logic [1:0] MARK_OPEN = 2'd2;
    localparam logic [1:0] MARK_DEAD = 2'd3;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    localparam logic [1:0] K_FWD_LAST = 2'd2;
    localparam logic [1:0] K_ALL_LAST = 2'd3;

    localparam logic CFG_GRID_ROWS = 1'b0;
    localparam logic CFG_GRID_COLS = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_READ_DATA,
        ST_START,
        ST_START_DATA,
        ST_TOP,
        ST_LOOK,
        ST_EVAL,
        ST_FINISH
    } gmd_state_t;

    typedef enum logic [1:0] {
        PH_FWD,
        PH_ALL,
        PH_BACK
    } gmd_phase_t;

    typedef struct packed {
        logic [1:0] mark;
        logic       status;
    } gmd_result_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } gmd_status_t;

    // turn order relative to heading: right, straight, left, back
    function automatic logic [1:0] look_offset(input logic [1:0] k);
        logic [1:0] off;
        begin
            case (k)
                2'd0:    off = 2'd1;
                2'd1:    off = 2'd0;
                2'd2:    off = 2'd3;
                default: off = 2'd2;
            endcase
            return off;
        end
    endfunction

endpackage

### src/gmd_ram.sv
// generic single-write, single-read synchronous ram with registered read
module gmd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/gmd_ctrl.sv
// controller: clearing sweep, cell write and read, depth-first walk sequencer
module gmd_ctrl #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [1:0]                                  in_op,
    input  logic [5:0]                                  in_row,
    input  logic [5:0]                                  in_col,
    input  logic                                        in_open_right,
    input  logic                                        in_open_down,
    input  logic                                        in_carved,
    input  logic [$clog2(MAX_ROWS)-1:0]                 last_row,
    input  logic [$clog2(MAX_COLS)-1:0]                 last_col,
    output logic                                        res_valid,
    input  logic                                        res_ready,
    output gmd_pkg::gmd_result_t                        res,
    output gmd_pkg::gmd_status_t                        stat,
    output logic                                        ram_wr_en,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] ram_wr_addr,
    output logic [gmd_pkg::CELL_W-1:0]                  ram_wr_data,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] ram_rd_addr,
    input  logic [gmd_pkg::CELL_W-1:0]                  ram_rd_data
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;

    gmd_pkg::gmd_state_t state_reg, state_next;
    gmd_pkg::gmd_phase_t phase_reg, phase_next;
    logic [1:0]    k_reg, k_next;
    logic [RW-1:0] walk_row_reg, walk_row_next;
    logic [CW-1:0] walk_col_reg, walk_col_next;
    logic [1:0]    heading_reg, heading_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic [RW-1:0] row_in_reg, row_in_next;
    logic [CW-1:0] col_in_reg, col_in_next;
    logic [1:0]    bits_in_reg, bits_in_next;
    logic          carved_reg, carved_next;
    logic          inside_reg, inside_next;
    logic [1:0]    cur_bits_reg, cur_bits_next;
    logic [RW-1:0] nb_row_reg, nb_row_next;
    logic [CW-1:0] nb_col_reg, nb_col_next;
    logic [1:0]    look_dir_reg, look_dir_next;
    logic          look_ok_reg, look_ok_next;
    logic [1:0]    res_mark_reg, res_mark_next;
    logic          res_status_reg, res_status_next;

    logic [1:0]    look_dir;
    logic [RW-1:0] nb_row;
    logic [CW-1:0] nb_col;
    logic          look_ok;
    logic          passage;
    logic [1:0]    nb_mark;
    logic          found_open;
    logic          found_path;
    logic          at_goal;

    // neighbour lookup for the current look and evaluation of the returned cell
    always_comb
    begin
        if (phase_reg == gmd_pkg::PH_BACK)
        begin
            look_dir = k_reg;
        end
        else
        begin
            look_dir = heading_reg + gmd_pkg::look_offset(k_reg);
        end
        nb_row  = walk_row_reg;
        nb_col  = walk_col_reg;
        look_ok = 1'b0;
        case (look_dir)
            gmd_pkg::DIR_RIGHT:
            begin
                nb_col  = walk_col_reg + CW'(1);
                look_ok = (walk_col_reg < last_col) && cur_bits_reg[0];
            end
            gmd_pkg::DIR_DOWN:
            begin
                nb_row  = walk_row_reg + RW'(1);
                look_ok = (walk_row_reg < last_row) && cur_bits_reg[1];
            end
            gmd_pkg::DIR_LEFT:
            begin
                nb_col  = walk_col_reg - CW'(1);
                look_ok = (walk_col_reg != '0);
            end
            default:
            begin
                nb_row  = walk_row_reg - RW'(1);
                look_ok = (walk_row_reg != '0);
            end
        endcase

        case (look_dir_reg)
            gmd_pkg::DIR_LEFT: passage = ram_rd_data[0];
            gmd_pkg::DIR_UP:   passage = ram_rd_data[1];
            default:           passage = 1'b1;
        endcase
        nb_mark    = (look_ok_reg && passage) ? ram_rd_data[3:2] : gmd_pkg::MARK_NONE;
        found_open = (nb_mark == gmd_pkg::MARK_OPEN);
        found_path = (nb_mark == gmd_pkg::MARK_PATH);
        at_goal    = (walk_row_reg == last_row) && (walk_col_reg == last_col);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gmd_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = gmd_pkg::ST_IDLE;
                end
            end
            gmd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_op)
                        gmd_pkg::OP_WRITE: state_next = gmd_pkg::ST_WRITE;
                        gmd_pkg::OP_SOLVE: state_next = gmd_pkg::ST_START;
                        gmd_pkg::OP_READ:  state_next = gmd_pkg::ST_READ;
                        default:           state_next = gmd_pkg::ST_FINISH;
                    endcase
                end
            end
            gmd_pkg::ST_WRITE:      state_next = gmd_pkg::ST_FINISH;
            gmd_pkg::ST_READ:       state_next = gmd_pkg::ST_READ_DATA;
            gmd_pkg::ST_READ_DATA:  state_next = gmd_pkg::ST_FINISH;
            gmd_pkg::ST_START:      state_next = gmd_pkg::ST_START_DATA;
            gmd_pkg::ST_START_DATA: state_next = gmd_pkg::ST_TOP;
            gmd_pkg::ST_TOP:
            begin
                state_next = at_goal ? gmd_pkg::ST_FINISH : gmd_pkg::ST_LOOK;
            end
            gmd_pkg::ST_LOOK:       state_next = gmd_pkg::ST_EVAL;
            gmd_pkg::ST_EVAL:
            begin
                unique case (phase_reg)
                    gmd_pkg::PH_FWD,
                    gmd_pkg::PH_ALL:
                    begin
                        state_next = found_open ? gmd_pkg::ST_TOP : gmd_pkg::ST_LOOK;
                    end
                    default:
                    begin
                        if (!found_path && k_reg == gmd_pkg::K_ALL_LAST)
                        begin
                            state_next = gmd_pkg::ST_FINISH;
                        end
                        else
                        begin
                            state_next = gmd_pkg::ST_LOOK;
                        end
                    end
                endcase
            end
            gmd_pkg::ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = gmd_pkg::ST_IDLE;
                end
            end
            default: state_next = gmd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = {walk_row_reg, walk_col_reg};
        ram_wr_data = {gmd_pkg::MARK_DEAD, cur_bits_reg};
        ram_rd_addr = {nb_row, nb_col};

        phase_next      = phase_reg;
        k_next          = k_reg;
        walk_row_next   = walk_row_reg;
        walk_col_next   = walk_col_reg;
        heading_next    = heading_reg;
        clr_addr_next   = clr_addr_reg;
        row_in_next     = row_in_reg;
        col_in_next     = col_in_reg;
        bits_in_next    = bits_in_reg;
        carved_next     = carved_reg;
        inside_next     = inside_reg;
        cur_bits_next   = cur_bits_reg;
        nb_row_next     = nb_row_reg;
        nb_col_next     = nb_col_reg;
        look_dir_next   = look_dir_reg;
        look_ok_next    = look_ok_reg;
        res_mark_next   = res_mark_reg;
        res_status_next = res_status_reg;

        unique case (state_reg)
            gmd_pkg::ST_CLEAR:
            begin
                ram_wr_en     = 1'b1;
                ram_wr_addr   = clr_addr_reg;
                ram_wr_data   = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            gmd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    row_in_next     = RW'(in_row);
                    col_in_next     = CW'(in_col);
                    bits_in_next    = {in_open_down, in_open_right};
                    carved_next     = in_carved;
                    inside_next     = (32'(in_row) < 32'(MAX_ROWS))
                                   && (32'(in_col) < 32'(MAX_COLS));
                    res_mark_next   = gmd_pkg::MARK_NONE;
                    res_status_next = 1'b0;
                end
            end
            gmd_pkg::ST_WRITE:
            begin
                ram_wr_en   = inside_reg;
                ram_wr_addr = {row_in_reg, col_in_reg};
                ram_wr_data = {carved_reg ? gmd_pkg::MARK_OPEN : gmd_pkg::MARK_NONE,
                               bits_in_reg};
            end
            gmd_pkg::ST_READ:
            begin
                ram_rd_addr = {row_in_reg, col_in_reg};
            end
            gmd_pkg::ST_READ_DATA:
            begin
                res_mark_next = inside_reg ? ram_rd_data[3:2] : gmd_pkg::MARK_NONE;
            end
            gmd_pkg::ST_START:
            begin
                ram_rd_addr   = '0;
                walk_row_next = '0;
                walk_col_next = '0;
                heading_next  = gmd_pkg::DIR_RIGHT;
            end
            gmd_pkg::ST_START_DATA:
            begin
                cur_bits_next = ram_rd_data[1:0];
                ram_wr_en     = 1'b1;
                ram_wr_addr   = '0;
                ram_wr_data   = {gmd_pkg::MARK_PATH, ram_rd_data[1:0]};
            end
            gmd_pkg::ST_TOP:
            begin
                phase_next = gmd_pkg::PH_FWD;
                k_next     = '0;
            end
            gmd_pkg::ST_LOOK:
            begin
                nb_row_next   = nb_row;
                nb_col_next   = nb_col;
                look_dir_next = look_dir;
                look_ok_next  = look_ok;
            end
            gmd_pkg::ST_EVAL:
            begin
                unique case (phase_reg)
                    gmd_pkg::PH_FWD:
                    begin
                        if (found_open)
                        begin
                            heading_next  = look_dir_reg;
                            walk_row_next = nb_row_reg;
                            walk_col_next = nb_col_reg;
                            cur_bits_next = ram_rd_data[1:0];
                            ram_wr_en     = 1'b1;
                            ram_wr_addr   = {nb_row_reg, nb_col_reg};
                            ram_wr_data   = {gmd_pkg::MARK_PATH, ram_rd_data[1:0]};
                        end
                        else if (k_reg == gmd_pkg::K_FWD_LAST)
                        begin
                            phase_next = gmd_pkg::PH_ALL;
                            k_next     = '0;
                        end
                        else
                        begin
                            k_next = k_reg + 2'd1;
                        end
                    end
                    gmd_pkg::PH_ALL:
                    begin
                        if (found_open)
                        begin
                            heading_next = look_dir_reg;
                        end
                        else if (k_reg == gmd_pkg::K_ALL_LAST)
                        begin
                            // dead end: mark the current cell before looking back
                            ram_wr_en  = 1'b1;
                            phase_next = gmd_pkg::PH_BACK;
                            k_next     = '0;
                        end
                        else
                        begin
                            k_next = k_reg + 2'd1;
                        end
                    end
                    default:
                    begin
                        if (found_path)
                        begin
                            walk_row_next = nb_row_reg;
                            walk_col_next = nb_col_reg;
                            cur_bits_next = ram_rd_data[1:0];
                            phase_next    = gmd_pkg::PH_ALL;
                            k_next        = '0;
                        end
                        else if (k_reg == gmd_pkg::K_ALL_LAST)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            k_next = k_reg + 2'd1;
                        end
                    end
                endcase
            end
            gmd_pkg::ST_FINISH:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gmd_pkg::ST_CLEAR;
            phase_reg    <= gmd_pkg::PH_FWD;
            k_reg        <= '0;
            walk_row_reg <= '0;
            walk_col_reg <= '0;
            heading_reg  <= gmd_pkg::DIR_RIGHT;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            k_reg        <= k_next;
            walk_row_reg <= walk_row_next;
            walk_col_reg <= walk_col_next;
            heading_reg  <= heading_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_in_reg     <= row_in_next;
        col_in_reg     <= col_in_next;
        bits_in_reg    <= bits_in_next;
        carved_reg     <= carved_next;
        inside_reg     <= inside_next;
        cur_bits_reg   <= cur_bits_next;
        nb_row_reg     <= nb_row_next;
        nb_col_reg     <= nb_col_next;
        look_dir_reg   <= look_dir_next;
        look_ok_reg    <= look_ok_next;
        res_mark_reg   <= res_mark_next;
        res_status_reg <= res_status_next;
    end

    assign res.mark      = res_mark_reg;
    assign res.status    = res_status_reg;
    assign stat.clearing = (state_reg == gmd_pkg::ST_CLEAR);
    assign stat.busy     = (state_reg != gmd_pkg::ST_IDLE);

endmodule

### src/grid_maze_depth_first_solver_core.sv
// top level of the grid maze depth-first solver: config registers, cell ram, controller, output
// a write passes WRITE, FINISH; a read READ, READ_DATA, FINISH; an unknown operation FINISH only
// a solve passes START, START_DATA, then TOP per step forward or turn and LOOK, EVAL per neighbour
// look; every look is one read of the single cell ram; no new item is taken until the return to IDLE
// after reset the cell ram is swept to zero, all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells (4096)
// reset: grid 64 x 64, walk at row 0, col 0 heading to next column, output empty
`include "grid_maze_depth_first_solver_core_macros.svh"

module grid_maze_depth_first_solver_core #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // row[5:0], col[11:6], open_right[12], open_down[13], carved[14]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // mark[1:0]
    output logic [0:0]  m_tuser,   // status[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 2 ** AW;

    logic [6:0]    grid_rows_reg;
    logic [6:0]    grid_cols_reg;
    logic [31:0]   rows_eff;
    logic [31:0]   cols_eff;
    logic [RW-1:0] last_row;
    logic [CW-1:0] last_col;

    logic          out_valid_reg;
    logic [1:0]    out_mark_reg;
    logic          out_status_reg;

    logic                  res_valid;
    logic                  res_ready;
    gmd_pkg::gmd_result_t  res;
    gmd_pkg::gmd_status_t  stat;

    logic                      ram_wr_en;
    logic [AW-1:0]             ram_wr_addr;
    logic [gmd_pkg::CELL_W-1:0] ram_wr_data;
    logic [AW-1:0]             ram_rd_addr;
    logic [gmd_pkg::CELL_W-1:0] ram_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= 7'd64;
            grid_cols_reg <= 7'd64;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gmd_pkg::CFG_GRID_ROWS: grid_rows_reg <= cfg_data;
                gmd_pkg::CFG_GRID_COLS: grid_cols_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (32'(grid_rows_reg) < 32'(gmd_pkg::GRID_MIN))
        begin
            rows_eff = 32'(gmd_pkg::GRID_MIN);
        end
        else if (32'(grid_rows_reg) > 32'(MAX_ROWS))
        begin
            rows_eff = 32'(MAX_ROWS);
        end
        else
        begin
            rows_eff = 32'(grid_rows_reg);
        end

        if (32'(grid_cols_reg) < 32'(gmd_pkg::GRID_MIN))
        begin
            cols_eff = 32'(gmd_pkg::GRID_MIN);
        end
        else if (32'(grid_cols_reg) > 32'(MAX_COLS))
        begin
            cols_eff = 32'(MAX_COLS);
        end
        else
        begin
            cols_eff = 32'(grid_cols_reg);
        end
    end

    assign last_row = RW'(rows_eff - 32'd1);
    assign last_col = CW'(cols_eff - 32'd1);

    gmd_ram #(
        .WIDTH (gmd_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    gmd_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tuser),
        .in_row        (s_tdata[5:0]),
        .in_col        (s_tdata[11:6]),
        .in_open_right (s_tdata[12]),
        .in_open_down  (s_tdata[13]),
        .in_carved     (s_tdata[14]),
        .last_row      (last_row),
        .last_col      (last_col),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .stat          (stat),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data)
    );

    // output register frees the controller while a result waits
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_mark_reg   <= res.mark;
            out_status_reg <= res.status;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {6'd0, out_mark_reg};
    assign m_tuser[0] = out_status_reg;

    `GMD_ASSERT_IMPLIES(a_no_traffic_while_clearing, clk, rst_n, stat.clearing, !s_tready && !m_tvalid)
    `GMD_ASSERT_NEXT(a_accept_starts_work, clk, rst_n, s_tvalid && s_tready, stat.busy)
    `GMD_ASSERT_NEXT(a_result_lands, clk, rst_n, res_valid && res_ready, m_tvalid && (m_tdata[1:0] == $past(res.mark)))

endmodule

### verif/tb.sv
// self-checking testbench for the grid maze depth-first solver core
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam int         ITEM_TARGET = 1650;
    localparam int         CYCLE_LIMIT = 2000000;
    localparam int         AREA_MAX    = 16;
    // turn offsets from the heading: right, straight, left, back
    localparam logic [1:0] TURN_ORDER [0:3] = '{2'd1, 2'd0, 2'd3, 2'd2};

    typedef struct {
        logic [1:0] mark;
        logic       status;
    } cell_reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [6:0]  cfg_data;

    logic [3:0]  cell_mem [0:4095];
    int          walk_r;
    int          walk_c;
    logic [1:0]  walk_heading;
    logic [6:0]  rows_cfg;
    logic [6:0]  cols_cfg;

    cell_reply_t pending_replies [$];
    int          items_sent;
    int          errors;
    int          cycle_count;
    bit          free_flow;

    grid_maze_depth_first_solver_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int grid_span(input logic [6:0] v);
        if (v < gmd_pkg::GRID_MIN)
            return gmd_pkg::GRID_MIN;
        if (v > 64)
            return 64;
        return int'(v);
    endfunction

    function automatic logic [1:0] mark_of(input int r, input int c);
        return cell_mem[r * 64 + c][3:2];
    endfunction

    function automatic void put_mark(input int r, input int c, input logic [1:0] m);
        cell_mem[r * 64 + c][3:2] = m;
    endfunction

    // blocked ways and grid edges read as MARK_NONE
    function automatic logic [1:0] neighbor_mark(input int rows, input int cols,
                                                 input logic [1:0] d);
        case (d)
            gmd_pkg::DIR_RIGHT:
                if (walk_c + 1 < cols && cell_mem[walk_r * 64 + walk_c][0])
                    return mark_of(walk_r, walk_c + 1);
            gmd_pkg::DIR_DOWN:
                if (walk_r + 1 < rows && cell_mem[walk_r * 64 + walk_c][1])
                    return mark_of(walk_r + 1, walk_c);
            gmd_pkg::DIR_LEFT:
                if (walk_c > 0 && cell_mem[walk_r * 64 + walk_c - 1][0])
                    return mark_of(walk_r, walk_c - 1);
            default:
                if (walk_r > 0 && cell_mem[(walk_r - 1) * 64 + walk_c][1])
                    return mark_of(walk_r - 1, walk_c);
        endcase
        return gmd_pkg::MARK_NONE;
    endfunction

    function automatic void walk_step(input logic [1:0] d);
        case (d)
            gmd_pkg::DIR_RIGHT: walk_c = walk_c + 1;
            gmd_pkg::DIR_DOWN:  walk_r = walk_r + 1;
            gmd_pkg::DIR_LEFT:  walk_c = walk_c - 1;
            default:            walk_r = walk_r - 1;
        endcase
    endfunction

    // returns 1 when the walk is boxed in
    function automatic logic walk_maze();
        int         rows;
        int         cols;
        int         k;
        logic       moved;
        logic       found;
        logic       stuck;
        logic [1:0] nd;
        rows = grid_span(rows_cfg);
        cols = grid_span(cols_cfg);
        walk_r = 0;
        walk_c = 0;
        walk_heading = gmd_pkg::DIR_RIGHT;
        put_mark(0, 0, gmd_pkg::MARK_PATH);
        while (walk_r != rows - 1 || walk_c != cols - 1)
        begin
            moved = 1'b0;
            for (k = 0; k < 3 && !moved; k++)
            begin
                nd = walk_heading + TURN_ORDER[k];
                if (neighbor_mark(rows, cols, nd) == gmd_pkg::MARK_OPEN)
                begin
                    walk_heading = nd;
                    walk_step(nd);
                    put_mark(walk_r, walk_c, gmd_pkg::MARK_PATH);
                    moved = 1'b1;
                end
            end
            stuck = !moved;
            while (stuck)
            begin
                found = 1'b0;
                for (k = 0; k < 4 && !found; k++)
                begin
                    nd = walk_heading + TURN_ORDER[k];
                    if (neighbor_mark(rows, cols, nd) == gmd_pkg::MARK_OPEN)
                    begin
                        walk_heading = nd;
                        found = 1'b1;
                    end
                end
                if (found)
                    stuck = 1'b0;
                else
                begin
                    put_mark(walk_r, walk_c, gmd_pkg::MARK_DEAD);
                    for (k = 0; k < 4 && !found; k++)
                    begin
                        if (neighbor_mark(rows, cols, 2'(k)) == gmd_pkg::MARK_PATH)
                        begin
                            walk_step(2'(k));
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic int pause_len();
        int p;
        p = $urandom_range(0, 99);
        if (free_flow || p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [6:0] pick_dim();
        int p;
        p = $urandom_range(0, 99);
        if (p < 6)
            return 7'($urandom_range(0, 1));
        if (p < 10)
            return 7'd64;
        if (p < 16)
            return 7'($urandom_range(65, 127));
        if (p < 22)
            return 7'($urandom_range(9, AREA_MAX));
        return 7'($urandom_range(2, 8));
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [5:0] r, input logic [5:0] c,
                             input logic o_right, input logic o_down, input logic carved);
        cell_reply_t reply;
        int          gap;
        reply.mark = gmd_pkg::MARK_NONE;
        reply.status = 1'b0;
        case (op)
            gmd_pkg::OP_WRITE:
                cell_mem[{r, c}] = {carved ? gmd_pkg::MARK_OPEN : gmd_pkg::MARK_NONE,
                                    o_down, o_right};
            gmd_pkg::OP_SOLVE: reply.status = walk_maze();
            gmd_pkg::OP_READ:  reply.mark = cell_mem[{r, c}][3:2];
            default:  ;
        endcase
        pending_replies.push_back(reply);
        items_sent++;
        gap = pause_len();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, carved, o_down, o_right, c, r};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == gmd_pkg::CFG_GRID_ROWS)
            rows_cfg = val;
        else
            cols_cfg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid and wait until every reply is back
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic check_corner_cells();
        send_item(gmd_pkg::OP_WRITE, 6'd63, 6'd63, 1'b1, 1'b1, 1'b1);
        send_item(gmd_pkg::OP_WRITE, 6'd0, 6'd63, 1'b1, 1'b0, 1'b0);
        send_item(gmd_pkg::OP_WRITE, 6'd63, 6'd0, 1'b0, 1'b1, 1'b1);
        send_item(gmd_pkg::OP_READ, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0);
        send_item(gmd_pkg::OP_READ, 6'd0, 6'd63, 1'b1, 1'b1, 1'b1);
        send_item(gmd_pkg::OP_READ, 6'd63, 6'd0, 1'b0, 1'b0, 1'b0);
        send_item(OP_NONE, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0);
        send_item(gmd_pkg::OP_READ, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0);
        send_item(gmd_pkg::OP_WRITE, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0);
        send_item(gmd_pkg::OP_READ, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic check_grid_clamps();
        settle();
        write_reg(gmd_pkg::CFG_GRID_ROWS, 7'd0);
        write_reg(gmd_pkg::CFG_GRID_COLS, 7'd1);
        // start cell left uncarved on purpose
        send_item(gmd_pkg::OP_WRITE, 6'd0, 6'd0, 1'b1, 1'b1, 1'b0);
        send_item(gmd_pkg::OP_WRITE, 6'd0, 6'd1, 1'b0, 1'b1, 1'b1);
        send_item(gmd_pkg::OP_WRITE, 6'd1, 6'd0, 1'b1, 1'b0, 1'b1);
        send_item(gmd_pkg::OP_WRITE, 6'd1, 6'd1, 1'b0, 1'b0, 1'b1);
        send_item(gmd_pkg::OP_SOLVE, 6'd63, 6'd63, 1'b1, 1'b1, 1'b1);
        send_item(gmd_pkg::OP_READ, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0);
        send_item(gmd_pkg::OP_READ, 6'd0, 6'd1, 1'b0, 1'b0, 1'b0);
        send_item(gmd_pkg::OP_READ, 6'd1, 6'd0, 1'b0, 1'b0, 1'b0);
        send_item(gmd_pkg::OP_READ, 6'd1, 6'd1, 1'b0, 1'b0, 1'b0);
        send_item(gmd_pkg::OP_SOLVE, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0);
        settle();
        write_reg(gmd_pkg::CFG_GRID_ROWS, 7'd127);
        write_reg(gmd_pkg::CFG_GRID_COLS, 7'd127);
        send_item(gmd_pkg::OP_SOLVE, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0);
        send_item(gmd_pkg::OP_READ, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic check_long_corridor();
        int i;
        settle();
        free_flow = 1'b1;
        write_reg(gmd_pkg::CFG_GRID_ROWS, 7'd64);
        write_reg(gmd_pkg::CFG_GRID_COLS, 7'd64);
        for (i = 0; i < 64; i++)
            send_item(gmd_pkg::OP_WRITE, 6'd0, 6'(i), i < 63, i == 63, 1'b1);
        for (i = 1; i < 64; i++)
            send_item(gmd_pkg::OP_WRITE, 6'(i), 6'd63, 1'b0, i < 63, 1'b1);
        send_item(gmd_pkg::OP_SOLVE, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0);
        free_flow = 1'b0;
        for (i = 0; i < 64; i += 9)
        begin
            send_item(gmd_pkg::OP_READ, 6'd0, 6'(i), 1'b0, 1'b0, 1'b0);
            send_item(gmd_pkg::OP_READ, 6'(63 - i), 6'd63, 1'b0, 1'b0, 1'b0);
        end
    endtask

    task automatic check_random_mazes();
        int span_r;
        int span_c;
        int r;
        int c;
        int n;
        int open_pct;
        int carve_pct;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            free_flow = ($urandom_range(0, 4) == 0);
            write_reg(gmd_pkg::CFG_GRID_ROWS, pick_dim());
            write_reg(gmd_pkg::CFG_GRID_COLS, pick_dim());
            span_r = grid_span(rows_cfg);
            span_c = grid_span(cols_cfg);
            if (span_r > AREA_MAX)
                span_r = AREA_MAX;
            if (span_c > AREA_MAX)
                span_c = AREA_MAX;
            if ($urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(10, 40);
                repeat (n)
                    send_item(2'($urandom_range(0, 3)), 6'($urandom), 6'($urandom),
                              1'($urandom), 1'($urandom), 1'($urandom));
            end
            else
            begin
                open_pct  = $urandom_range(45, 90);
                carve_pct = $urandom_range(80, 100);
                for (r = 0; r < span_r; r++)
                    for (c = 0; c < span_c; c++)
                        send_item(gmd_pkg::OP_WRITE, 6'(r), 6'(c),
                                  $urandom_range(0, 99) < open_pct,
                                  $urandom_range(0, 99) < open_pct,
                                  $urandom_range(0, 99) < carve_pct);
                send_item(gmd_pkg::OP_SOLVE, 6'($urandom), 6'($urandom),
                          1'($urandom), 1'($urandom), 1'($urandom));
                n = $urandom_range(4, 16);
                repeat (n)
                    send_item(gmd_pkg::OP_READ, 6'($urandom_range(0, span_r - 1)),
                              6'($urandom_range(0, span_c - 1)),
                              1'($urandom), 1'($urandom), 1'($urandom));
                // walk again over the marks left behind
                if ($urandom_range(0, 4) == 0)
                begin
                    send_item(gmd_pkg::OP_SOLVE, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0);
                    send_item(gmd_pkg::OP_READ, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0);
                end
            end
        end
    endtask

    initial
    begin : sink_pacing
        int n;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!free_flow && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
                repeat (n) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : reply_check
        cell_reply_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual mark %0d status %0d",
                             $time, m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (m_tdata !== {6'd0, want.mark})
                    begin
                        $display("%0t: mark mismatch, expected %0d, actual %0d",
                                 $time, want.mark, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < 4096; i++)
            cell_mem[i] = 4'd0;
        walk_r       = 0;
        walk_c       = 0;
        walk_heading = gmd_pkg::DIR_RIGHT;
        rows_cfg     = 7'd64;
        cols_cfg     = 7'd64;
        items_sent   = 0;
        errors       = 0;
        free_flow    = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 16'd0;
        s_tuser      = gmd_pkg::OP_WRITE;
        cfg_valid    = 1'b0;
        cfg_index    = gmd_pkg::CFG_GRID_ROWS;
        cfg_data     = 7'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_corner_cells();
        check_grid_clamps();
        check_long_corridor();
        check_random_mazes();

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/gmd_pkg.sv
src/gmd_ram.sv
src/gmd_ctrl.sv
src/grid_maze_depth_first_solver_core.sv
verif/tb.sv
